>>> rtl/assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// holds on every clock edge out of reset
`define NFB_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define NFB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/nfb_pkg.sv
`default_nettype none

package nfb_pkg;

    localparam int ROUND_COUNT = 36;
    localparam int CNT_W       = $clog2(ROUND_COUNT + 1);

    localparam int BLOCK_W = 64;
    localparam int KEY_W   = 128;
    localparam int RC_W    = 6;

    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    localparam logic [3:0] SBOX [0:15] = '{
        4'hc, 4'h0, 4'hf, 4'ha, 4'h2, 4'hb, 4'h9, 4'h5,
        4'h8, 4'h3, 4'hd, 4'h7, 4'h1, 4'he, 4'h6, 4'h4
    };

    localparam logic [RC_W-1:0] RC_TABLE [0:35] = '{
        6'h01, 6'h02, 6'h04, 6'h08, 6'h10, 6'h20, 6'h03, 6'h06, 6'h0c,
        6'h18, 6'h13, 6'h05, 6'h0a, 6'h14, 6'h0b, 6'h16, 6'h2c, 6'h1b,
        6'h36, 6'h2f, 6'h1d, 6'h3a, 6'h37, 6'h2d, 6'h1b, 6'h36, 6'h2f,
        6'h1d, 6'h3a, 6'h37, 6'h2d, 6'h1b, 6'h36, 6'h2f, 6'h1d, 6'h3a
    };

    function automatic logic [RC_W-1:0] round_const(input int r);
        logic [RC_W-1:0] c;
        c = '0;
        if (r >= 0 && r < 36)
        begin
            c = RC_TABLE[r];
        end
        return c;
    endfunction

    function automatic logic [15:0] sub_word(input logic [15:0] w);
        logic [15:0] r;
        for (int k = 0; k < 4; k++)
        begin
            r[4*k +: 4] = SBOX[w[4*k +: 4]];
        end
        return r;
    endfunction

    // key words kw0..kw7 sit from the top of the vector down
    function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k);
        return {k[111:0], sub_word(k[127:112])};
    endfunction

    // nibble 0 is the top nibble of the block
    function automatic logic [BLOCK_W-1:0] round_data(
        input logic [BLOCK_W-1:0] d,
        input logic [KEY_W-1:0]   k,
        input logic [RC_W-1:0]    rc
    );
        logic [31:0]        rk;
        logic [3:0]         s;
        logic [BLOCK_W-1:0] v;
        rk = {k[111:96], k[79:64]} ^ {14'd0, rc, 12'd0} ^ {22'd0, rc, 4'd0};
        v  = d;
        for (int i = 0; i < 8; i++)
        begin
            s                 = SBOX[d[63-4*i -: 4]];
            v[63-4*i -: 4]    = s;
            v[31-4*i -: 4]    = d[31-4*i -: 4] ^ s;
        end
        return {v[59:0], v[63:60]} ^ {rk, 32'd0};
    endfunction

endpackage

`default_nettype wire

>>> rtl/nfb_cfg.sv
`default_nettype none

module nfb_cfg
    import nfb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_index,
    input  wire logic [63:0]      cfg_data,
    output logic      [KEY_W-1:0] key
);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic [63:0] key_high_next;
    logic [63:0] key_low_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        key_high_next = key_high_reg;
        key_low_next  = key_low_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KEY_HIGH: key_high_next = cfg_data;
                REG_KEY_LOW:  key_low_next  = cfg_data;
                default:      key_high_next = key_high_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else
        begin
            key_high_reg <= key_high_next;
            key_low_reg  <= key_low_next;
        end
    end

    assign key = {key_high_reg, key_low_reg};

endmodule

`default_nettype wire

>>> rtl/nfb_round.sv
`default_nettype none
`include "assert_macros.svh"

module nfb_round
    import nfb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [BLOCK_W-1:0] in_data,
    input  wire logic [KEY_W-1:0]   in_key,
    input  wire logic [RC_W-1:0]    rc,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [BLOCK_W-1:0] out_data,
    output logic      [KEY_W-1:0]   out_key
);

    logic               valid_reg;
    logic [BLOCK_W-1:0] data_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [BLOCK_W-1:0] data_next;
    logic [KEY_W-1:0]   key_next;

    assign in_ready  = !valid_reg || out_ready;
    assign data_next = round_data(in_data, in_key, rc);
    assign key_next  = key_update(in_key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload only moves with a request
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
            key_reg  <= key_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_key   = key_reg;

    `NFB_ASSERT_IMPL(a_no_overwrite, valid_reg && !out_ready, !in_ready, "stage overwritten while held")

endmodule

`default_nettype wire

>>> rtl/nibble_feistel_block_encrypt.sv
`default_nettype none
`include "assert_macros.svh"

// 64-bit block encryption under a 128-bit key, one round per pipeline stage.
// A request is taken on any cycle in which in_ready is high, so one block per
// cycle is sustained while out_ready stays high; the ciphertext passes through
// the ROUND_COUNT (36) round registers, of which the last is the output
// register. Each stage stalls only when it is full and the next stage cannot
// take its contents, so empty slots are squeezed out under back-pressure. The
// key schedule travels with each block, so the user must write the key words
// on the configuration port (index 0 upper half, key byte 0 most significant;
// index 1 lower half, both reset to zero) only while no request is in flight;
// the block itself does not enforce this, and a write is taken on every cycle.
module nibble_feistel_block_encrypt
    import nfb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [63:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [BLOCK_W-1:0] plaintext,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [BLOCK_W-1:0] ciphertext
);

    logic                     stg_valid [0:ROUND_COUNT];
    logic                     stg_ready [0:ROUND_COUNT];
    logic [BLOCK_W-1:0]       stg_data  [0:ROUND_COUNT];
    logic [KEY_W-1:0]         stg_key   [0:ROUND_COUNT-1];
    logic [ROUND_COUNT-1:0]   valid_vec;
    logic [CNT_W-1:0]         occ_reg;
    logic [CNT_W-1:0]         occ_next;
    logic                     in_acc;
    logic                     out_acc;

    nfb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key       (stg_key[0])
    );

    assign stg_valid[0] = in_valid;
    assign in_ready     = stg_ready[0];
    assign stg_data[0]  = plaintext;

    genvar g;
    generate
        for (g = 0; g < ROUND_COUNT; g++)
        begin : g_round
            if (g < ROUND_COUNT - 1)
            begin : g_mid
                nfb_round u_round (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .in_valid  (stg_valid[g]),
                    .in_ready  (stg_ready[g]),
                    .in_data   (stg_data[g]),
                    .in_key    (stg_key[g]),
                    .rc        (round_const(g)),
                    .out_valid (stg_valid[g+1]),
                    .out_ready (stg_ready[g+1]),
                    .out_data  (stg_data[g+1]),
                    .out_key   (stg_key[g+1])
                );
            end
            else
            begin : g_last
                nfb_round u_round (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .in_valid  (stg_valid[g]),
                    .in_ready  (stg_ready[g]),
                    .in_data   (stg_data[g]),
                    .in_key    (stg_key[g]),
                    .rc        (round_const(g)),
                    .out_valid (stg_valid[g+1]),
                    .out_ready (stg_ready[g+1]),
                    .out_data  (stg_data[g+1]),
                    .out_key   ()
                );
            end
            assign valid_vec[g] = stg_valid[g+1];
        end
    endgenerate

    assign stg_ready[ROUND_COUNT] = out_ready;
    assign out_valid              = stg_valid[ROUND_COUNT];
    assign ciphertext             = stg_data[ROUND_COUNT];

    // blocks in flight, for checking only
    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        occ_next = occ_reg;
        if (in_acc && !out_acc)
        begin
            occ_next = occ_reg + CNT_W'(1);
        end
        else if (!in_acc && out_acc)
        begin
            occ_next = occ_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    `NFB_ASSERT_ALWAYS(a_occ_match, occ_reg == CNT_W'($countones(valid_vec)), "block lost")
    `NFB_ASSERT_ALWAYS(a_occ_bound, occ_reg <= CNT_W'(ROUND_COUNT), "more blocks in flight than stages")
    `NFB_ASSERT_IMPL(a_out_has_block, out_valid, occ_reg != '0, "result with no block in flight")

endmodule

`default_nettype wire
